FILE: hdl/cbrd_pkg.sv
package cbrd_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int CNT_W      = 11;
    localparam int ADDR_W     = COL_W + 1;
    localparam int DEPTH      = 2 * MAX_WIDTH;

    localparam logic [CNT_W-1:0] WIDTH_RST  = 11'd352;
    localparam logic [CNT_W-1:0] HEIGHT_RST = 11'd288;
    localparam logic [CNT_W-1:0] WIDTH_MIN  = 11'd2;
    localparam logic [CNT_W-1:0] HEIGHT_MIN = 11'd1;
    localparam logic [CNT_W-1:0] WIDTH_MAX  = CNT_W'(MAX_WIDTH);
    localparam logic [CNT_W-1:0] HEIGHT_MAX = CNT_W'(MAX_HEIGHT);

    // row headers
    localparam logic [15:0] HDR_RAW   = 16'h0FF0;
    localparam logic [15:0] HDR_STEP5 = 16'h1EE1;
    localparam logic [15:0] HDR_STEP9 = 16'h2DD2;
    localparam logic [15:0] HDR_STEP17 = 16'h3CC3;
    localparam logic [15:0] HDR_COPY  = 16'h4BB4;

    // row modes
    localparam logic [2:0] MODE_RAW = 3'd0;
    localparam logic [2:0] MODE_S5  = 3'd1;
    localparam logic [2:0] MODE_S9  = 3'd2;
    localparam logic [2:0] MODE_S17 = 3'd3;
    localparam logic [2:0] MODE_COPY = 3'd4;

    // parse phases
    localparam logic [2:0] PH_HDR_HI = 3'd0;
    localparam logic [2:0] PH_HDR_LO = 3'd1;
    localparam logic [2:0] PH_BODY   = 3'd2;
    localparam logic [2:0] PH_PAD    = 3'd3;
    localparam logic [2:0] PH_COPY   = 3'd4;
    localparam logic [2:0] PH_IDLE   = 3'd5;

    // result status
    localparam logic [1:0] ST_PIXEL  = 2'd0;
    localparam logic [1:0] ST_BADHDR = 2'd1;
    localparam logic [1:0] ST_SHORT  = 2'd2;
    localparam logic [1:0] ST_INCOPY = 2'd3;

    // opcodes
    localparam logic OP_DATA  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [3:0] MAX_RESULTS = 4'd9;

    typedef struct packed {
        logic [7:0]       pixel;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             frame_done;
        logic [1:0]       status;
    } res_t;

endpackage

FILE: hdl/compressed_bayer_row_decoder.sv
// Sequence: an accepted word runs through the execute, finish and flush states; a
// compressed body word also runs the bit-serial code shifter in the bit state, one
// code bit per step, and leaves it early when the row ends inside the word. No new
// word is taken until the last one is through; a stalled result port holds the sequencer.
// Reset (aresetn low, synchronous): clears parsing state, registers to 352 x 288 and
// marks both halves of the line store empty by per-half fill counts, with no sweep.
module compressed_bayer_row_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // frame_last
    input  logic [1:0]  s_tuser,   // [0] opcode, [1] frame_first
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] pixel, [17:8] pixel_row, [27:18] pixel_column
    output logic        m_tlast,   // last_of_run
    output logic [2:0]  m_tuser,   // [0] frame_done, [2:1] status
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cbrd_pkg::*;

    // sequencer states
    localparam logic [2:0] S_WAIT  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_BITS  = 3'd2;
    localparam logic [2:0] S_FIN   = 3'd3;
    localparam logic [2:0] S_FLUSH = 3'd4;

    // configuration
    logic [CNT_W-1:0] fw_reg, fh_reg, w_eff, h_eff;

    // sequencer and latched word
    logic [2:0] st_reg, st_next;
    logic       op_reg, last_reg;
    logic [7:0] byte_reg;

    // row parsing state
    logic [2:0]       phase_reg, phase_next;
    logic [2:0]       mode_reg, mode_next;
    logic [7:0]       hh_reg, hh_next;
    logic [CNT_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0] fill_reg [2];
    logic [CNT_W-1:0] fill_next [2];
    logic [7:0]       p1_reg, p1_next, p2_reg, p2_next;
    logic             par_reg, par_next, par_eff;
    logic [3:0]       cnt_reg, cnt_next;

    // bit-serial code shifter
    logic [10:0] code_reg, code_next, code_n;
    logic [3:0]  clen_reg, clen_next, clen_n;
    logic        escf_reg, escf_next;
    logic [7:0]  sh_reg, sh_next;
    logic [3:0]  scnt_reg, scnt_next;

    // line store
    logic [7:0]        mem [DEPTH];
    logic [7:0]        rd_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [7:0]        mem_wd;

    // result path: hold stage, then output register
    res_t hold_reg, out_reg, push_res;
    logic hold_v_reg, out_v_reg, out_last_reg;
    logic push, flush, out_free, stall;

    // per-step helpers
    logic             pp_en, pp_keep, row_end;
    logic [7:0]       pp_pix, copy_pix, esc_pix, clip_pix;
    logic [CNT_W-1:0] col_inc, row_inc;
    logic [15:0]      word;
    logic [4:0]       step;
    logic [3:0]       esc;
    logic             done, absolute, dneg;
    logic [2:0]       dmag;
    logic [7:0]       prod;
    logic signed [10:0] v;
    logic             accept, cfg_wr;

    assign pready   = 1'b1;
    assign cfg_wr   = psel & penable & pwrite;
    assign prdata   = (paddr[2] == REG_HEIGHT) ? {21'd0, fh_reg} : {21'd0, fw_reg};
    assign s_tready = (st_reg == S_WAIT);
    assign accept   = s_tvalid & s_tready;

    assign w_eff = (fw_reg < WIDTH_MIN) ? WIDTH_MIN : ((fw_reg > WIDTH_MAX) ? WIDTH_MAX : fw_reg);
    assign h_eff = (fh_reg < HEIGHT_MIN) ? HEIGHT_MIN :
                   ((fh_reg > HEIGHT_MAX) ? HEIGHT_MAX : fh_reg);

    assign col_inc  = {1'b0, col_reg} + CNT_W'(1);
    assign row_inc  = row_reg + CNT_W'(1);
    assign word     = {hh_reg, byte_reg};
    assign copy_pix = (col_inc <= fill_reg[row_reg[0]]) ? rd_reg : 8'd0;
    assign mem_addr = {row_reg[0], col_reg};

    // step and escape length of the current compressed row
    always_comb begin
        case (mode_reg)
            MODE_S5:  begin step = 5'd5;  esc = 4'd6; end
            MODE_S9:  begin step = 5'd9;  esc = 4'd5; end
            default:  begin step = 5'd17; esc = 4'd4; end
        endcase
    end

    // decode one more code bit
    assign code_n = {code_reg[9:0], sh_reg[7]};
    assign clen_n = clen_reg + 4'd1;

    always_comb begin
        done     = 1'b0;
        absolute = 1'b0;
        dneg     = 1'b0;
        dmag     = 3'd0;
        if (escf_reg) begin
            if (clen_n == 4'd5 + esc) begin
                done     = 1'b1;
                absolute = 1'b1;
            end
        end else begin
            case (clen_n)
                4'd2: begin
                    if (code_n[1:0] != 2'b11) begin
                        done = 1'b1;
                        dmag = {2'b00, code_n[1] | code_n[0]};
                        dneg = code_n[0];
                    end
                end
                4'd4: begin
                    if (code_n[3:1] == 3'b110) begin
                        done = 1'b1;
                        dmag = 3'd2;
                        dneg = ~code_n[0];
                    end
                end
                4'd5: begin
                    if (code_n[4:1] == 4'b1110) begin
                        done = 1'b1;
                        dmag = 3'd3;
                        dneg = ~code_n[0];
                    end
                end
                4'd6: begin
                    done = 1'b1;
                    dmag = 3'd4;
                    dneg = ~code_n[0];
                end
                default: ;
            endcase
        end
    end

    assign prod = {5'd0, dmag} * {3'd0, step};
    assign v    = dneg ? ($signed({3'b000, p2_reg}) - $signed({3'b000, prod}))
                       : ($signed({3'b000, p2_reg}) + $signed({3'b000, prod}));
    assign clip_pix = v[10] ? 8'd0 : ((v > 11'sd255) ? 8'd255 : v[7:0]);

    always_comb begin
        case (esc)
            4'd6:    esc_pix = {code_n[5:0], 2'b00};
            4'd5:    esc_pix = {code_n[4:0], 3'b000};
            default: esc_pix = {code_n[3:0], 4'b0000};
        endcase
    end

    // sequencer
    always_comb begin
        st_next    = st_reg;
        phase_next = phase_reg;
        mode_next  = mode_reg;
        hh_next    = hh_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        fill_next  = fill_reg;
        p1_next    = p1_reg;
        p2_next    = p2_reg;
        par_next   = par_reg;
        par_eff    = par_reg;
        cnt_next   = cnt_reg;
        code_next  = code_reg;
        clen_next  = clen_reg;
        escf_next  = escf_reg;
        sh_next    = sh_reg;
        scnt_next  = scnt_reg;
        push       = 1'b0;
        push_res   = '0;
        flush      = 1'b0;
        pp_en      = 1'b0;
        pp_keep    = 1'b0;
        pp_pix     = 8'd0;
        row_end    = 1'b0;
        mem_we     = 1'b0;
        mem_wd     = 8'd0;

        push_res.row = row_reg[ROW_W-1:0];
        push_res.col = col_reg;

        case (st_reg)
            S_WAIT: begin
                if (accept) begin
                    st_next  = S_EXEC;
                    cnt_next = 4'd0;
                    // frame start: drop all parsing state, empty the line store
                    if (s_tuser[0] == OP_DATA && s_tuser[1]) begin
                        phase_next = PH_HDR_HI;
                        mode_next  = MODE_RAW;
                        hh_next    = 8'd0;
                        row_next   = '0;
                        col_next   = '0;
                        fill_next[0] = '0;
                        fill_next[1] = '0;
                        p1_next    = 8'd0;
                        p2_next    = 8'd0;
                        par_next   = 1'b0;
                        code_next  = '0;
                        clen_next  = 4'd0;
                        escf_next  = 1'b0;
                    end
                end
            end
            S_EXEC: begin
                st_next = S_FIN;
                if (op_reg == OP_DRAIN) begin
                    if (phase_reg == PH_COPY) begin
                        pp_en  = 1'b1;
                        pp_pix = copy_pix;
                    end
                end else begin
                    case (phase_reg)
                        PH_HDR_HI: begin
                            hh_next    = byte_reg;
                            phase_next = PH_HDR_LO;
                        end
                        PH_HDR_LO: begin
                            col_next   = '0;
                            p1_next    = 8'd0;
                            p2_next    = 8'd0;
                            code_next  = '0;
                            clen_next  = 4'd0;
                            escf_next  = 1'b0;
                            par_next   = 1'b0;
                            phase_next = PH_BODY;
                            case (word)
                                HDR_RAW:    mode_next = MODE_RAW;
                                HDR_STEP5:  mode_next = MODE_S5;
                                HDR_STEP9:  mode_next = MODE_S9;
                                HDR_STEP17: mode_next = MODE_S17;
                                HDR_COPY: begin
                                    mode_next  = MODE_COPY;
                                    phase_next = PH_COPY;
                                end
                                default: begin
                                    push            = 1'b1;
                                    push_res.status = ST_BADHDR;
                                    push_res.col    = '0;
                                    phase_next      = PH_IDLE;
                                end
                            endcase
                        end
                        PH_BODY: begin
                            if (mode_reg != MODE_RAW) begin
                                par_next = ~par_reg;
                                par_eff  = ~par_reg;
                            end
                            if (mode_reg == MODE_RAW || col_reg < COL_W'(2)) begin
                                pp_en   = 1'b1;
                                pp_keep = 1'b1;
                                pp_pix  = byte_reg;
                            end else begin
                                sh_next   = byte_reg;
                                scnt_next = 4'd8;
                                st_next   = S_BITS;
                            end
                        end
                        PH_PAD: phase_next = PH_HDR_HI;
                        PH_COPY: begin
                            push            = 1'b1;
                            push_res.status = ST_INCOPY;
                        end
                        default: ;
                    endcase
                end
            end
            S_BITS: begin
                sh_next   = {sh_reg[6:0], 1'b0};
                scnt_next = scnt_reg - 4'd1;
                if (done) begin
                    pp_en     = 1'b1;
                    pp_keep   = 1'b1;
                    pp_pix    = absolute ? esc_pix : clip_pix;
                    code_next = '0;
                    clen_next = 4'd0;
                    escf_next = 1'b0;
                end else begin
                    code_next = code_n;
                    clen_next = clen_n;
                    if (clen_n == 4'd5 && code_n[4:0] == 5'b11111) begin
                        escf_next = 1'b1;
                    end
                end
                if (scnt_reg == 4'd1) begin
                    st_next = S_FIN;
                end
            end
            S_FIN: begin
                st_next = S_FLUSH;
                // early frame end
                if (last_reg && op_reg == OP_DATA && phase_reg != PH_IDLE &&
                    !(phase_reg == PH_COPY && row_inc >= h_eff)) begin
                    phase_next = PH_IDLE;
                    if (cnt_reg < MAX_RESULTS) begin
                        push            = 1'b1;
                        push_res.status = ST_SHORT;
                    end
                end
            end
            S_FLUSH: begin
                flush   = 1'b1;
                st_next = S_WAIT;
            end
            default: st_next = S_WAIT;
        endcase

        // emit one pixel (stored unless it is a copy) and advance the column, closing the row at its end
        if (pp_en) begin
            mem_we          = pp_keep;
            mem_wd          = pp_pix;
            if (pp_keep && col_inc > fill_reg[row_reg[0]]) begin
                fill_next[row_reg[0]] = col_inc;
            end
            p2_next         = p1_reg;
            p1_next         = pp_pix;
            push            = 1'b1;
            push_res.pixel  = pp_pix;
            push_res.status = ST_PIXEL;
            if (col_inc >= w_eff) begin
                row_end   = 1'b1;
                row_next  = row_inc;
                col_next  = '0;
                p1_next   = 8'd0;
                p2_next   = 8'd0;
                code_next = '0;
                clen_next = 4'd0;
                escf_next = 1'b0;
                if (row_inc >= h_eff) begin
                    phase_next          = PH_IDLE;
                    push_res.frame_done = 1'b1;
                end else if (mode_reg != MODE_RAW && mode_reg != MODE_COPY && par_eff) begin
                    phase_next = PH_PAD;
                end else begin
                    phase_next = PH_HDR_HI;
                end
            end else begin
                col_next = col_inc[COL_W-1:0];
            end
        end
        if (row_end && st_reg == S_BITS) begin
            st_next = S_FIN;
        end
        if (push) begin
            cnt_next = cnt_reg + 4'd1;
        end
    end

    assign out_free = ~out_v_reg | m_tready;
    assign stall    = (push | flush) & hold_v_reg & ~out_free;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg <= WIDTH_RST;
            fh_reg <= HEIGHT_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_HEIGHT) begin
                fh_reg <= pwdata[CNT_W-1:0];
            end else begin
                fw_reg <= pwdata[CNT_W-1:0];
            end
        end
    end

    // latch the accepted word
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg   <= s_tuser[0];
            last_reg <= s_tlast;
            byte_reg <= s_tdata;
        end
    end

    // sequencer and parsing state; hold everything while the result path is full
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= S_WAIT;
            phase_reg   <= PH_HDR_HI;
            mode_reg    <= MODE_RAW;
            hh_reg      <= 8'd0;
            row_reg     <= '0;
            col_reg     <= '0;
            fill_reg[0] <= '0;
            fill_reg[1] <= '0;
            p1_reg      <= 8'd0;
            p2_reg      <= 8'd0;
            par_reg     <= 1'b0;
            cnt_reg     <= 4'd0;
            code_reg    <= '0;
            clen_reg    <= 4'd0;
            escf_reg    <= 1'b0;
            sh_reg      <= 8'd0;
            scnt_reg    <= 4'd0;
        end else if (!stall) begin
            st_reg    <= st_next;
            phase_reg <= phase_next;
            mode_reg  <= mode_next;
            hh_reg    <= hh_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            fill_reg  <= fill_next;
            p1_reg    <= p1_next;
            p2_reg    <= p2_next;
            par_reg   <= par_next;
            cnt_reg   <= cnt_next;
            code_reg  <= code_next;
            clen_reg  <= clen_next;
            escf_reg  <= escf_next;
            sh_reg    <= sh_next;
            scnt_reg  <= scnt_next;
        end
    end

    // line store: one write port, registered read at the current row half and column
    always_ff @(posedge aclk) begin
        if (mem_we && !stall) begin
            mem[mem_addr] <= mem_wd;
        end
        rd_reg <= mem[mem_addr];
    end

    // result path: a new result waits in the hold stage until the next one, or the end
    // of the word, tells whether it is the last of its run
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_v_reg   <= 1'b0;
            out_v_reg    <= 1'b0;
            out_last_reg <= 1'b0;
        end else if (push && !stall) begin
            hold_reg   <= push_res;
            hold_v_reg <= 1'b1;
            if (hold_v_reg) begin
                out_reg      <= hold_reg;
                out_last_reg <= 1'b0;
                out_v_reg    <= 1'b1;
            end else if (out_free) begin
                out_v_reg <= 1'b0;
            end
        end else if (flush && hold_v_reg && out_free) begin
            out_reg      <= hold_reg;
            out_last_reg <= 1'b1;
            out_v_reg    <= 1'b1;
            hold_v_reg   <= 1'b0;
        end else if (out_free) begin
            out_v_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {4'd0, out_reg.col, out_reg.row, out_reg.pixel};
    assign m_tuser  = {out_reg.status, out_reg.frame_done};

endmodule

FILE: verif/bayer_row_checker.sv
`timescale 1ns / 1ps

module bayer_row_checker
    import cbrd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        m_tlast,
    input  logic [2:0]  m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pixels_owed
);

    typedef struct packed {
        logic [7:0] pix;
        logic [9:0] row;
        logic [9:0] col;
        logic       run_end;
        logic       done;
        logic [1:0] st;
    } pixel_word_t;

    pixel_word_t owed_q[$];
    pixel_word_t word_buf[9];
    int          word_n;

    logic [7:0]  line_mem [DEPTH];
    int unsigned row_cnt, col_cnt, hdr_hi, bit_buf, bit_cnt, bits_used, last_two;
    logic [2:0]  phase, mode;
    int unsigned cfg_width, cfg_height;

    function automatic int unsigned width_now();
        if (cfg_width < 2) return 2;
        if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
        return cfg_width;
    endfunction

    function automatic int unsigned height_now();
        if (cfg_height < 1) return 1;
        if (cfg_height > MAX_HEIGHT) return MAX_HEIGHT;
        return cfg_height;
    endfunction

    function automatic void push_word(int unsigned pix, logic [1:0] st);
        if (word_n >= MAX_RESULTS) return;
        word_buf[word_n] = '{pix[7:0], 10'(row_cnt), 10'(col_cnt), 1'b0, 1'b0, st};
        word_n++;
    endfunction

    function automatic void clear_frame();
        foreach (line_mem[i]) line_mem[i] = 8'd0;
        row_cnt = 0; col_cnt = 0; phase = PH_HDR_HI; hdr_hi = 0; mode = MODE_RAW;
        bit_buf = 0; bit_cnt = 0; bits_used = 0; last_two = 0;
    endfunction

    function automatic void place_pixel(int unsigned pix, bit keep);
        bit pad;
        pix &= 8'hFF;
        if (keep && col_cnt < MAX_WIDTH) line_mem[(row_cnt & 1) * MAX_WIDTH + col_cnt] = pix[7:0];
        last_two = ((last_two << 8) | pix) & 16'hFFFF;
        push_word(pix, ST_PIXEL);
        col_cnt++;
        if (col_cnt < width_now()) return;
        pad = mode >= MODE_S5 && mode <= MODE_S17 && (((bits_used + bit_cnt) >> 3) & 1);
        row_cnt++;
        col_cnt = 0; bit_buf = 0; bit_cnt = 0; last_two = 0;
        if (row_cnt >= height_now()) begin
            phase = PH_IDLE;
            if (word_n > 0) word_buf[word_n - 1].done = 1'b1;
        end else begin
            phase = pad ? PH_PAD : PH_HDR_HI;
        end
    endfunction

    function automatic int unsigned peek_bits(int unsigned k);
        return (bit_buf >> (bit_cnt - k)) & ((1 << k) - 1);
    endfunction

    // pull as many complete codes from the bit buffer as are there
    function automatic void decode_codes();
        int step, f, len, d, v;
        int unsigned esc, t, pix;
        bit absolute;
        step = mode == MODE_S5 ? 5 : (mode == MODE_S9 ? 9 : 17);
        esc  = mode == MODE_S5 ? 6 : (mode == MODE_S9 ? 5 : 4);
        while (phase == PH_BODY && word_n < MAX_RESULTS) begin
            f = bit_cnt; d = 0; absolute = 0;
            if (f < 2) break;
            t = peek_bits(2);
            if (t != 3) begin
                len = 2;
                d = t == 0 ? 0 : (t == 1 ? -1 : 1);
            end else begin
                if (f < 4) break;
                t = peek_bits(4);
                if (t == 'hC) begin
                    len = 4; d = -2;
                end else if (t == 'hD) begin
                    len = 4; d = 2;
                end else begin
                    if (f < 5) break;
                    t = peek_bits(5);
                    if (t == 'h1C) begin
                        len = 5; d = -3;
                    end else if (t == 'h1D) begin
                        len = 5; d = 3;
                    end else if (t == 'h1E) begin
                        if (f < 6) break;
                        len = 6;
                        d = peek_bits(6) == 'h3C ? -4 : 4;
                    end else begin
                        if (f < 5 + esc) break;
                        len = 5 + esc;
                        absolute = 1;
                    end
                end
            end
            if (absolute) begin
                pix = ((bit_buf >> (f - len)) & ((1 << esc) - 1)) << (8 - esc);
            end else begin
                v = int'(last_two >> 8) + d * step;
                if (v < 0) v = 0;
                if (v > 255) v = 255;
                pix = v;
            end
            bit_cnt = f - len;
            bit_buf &= (1 << bit_cnt) - 1;
            bits_used = (bits_used + len) & 16'h3FFF;
            place_pixel(pix, 1);
        end
    endfunction

    function automatic void take_header(int unsigned lo);
        logic [15:0] hdr;
        hdr = 16'((hdr_hi << 8) | lo);
        bits_used = 16; last_two = 0; bit_buf = 0; bit_cnt = 0; col_cnt = 0;
        phase = PH_BODY;
        case (hdr)
            HDR_RAW:    mode = MODE_RAW;
            HDR_STEP5:  mode = MODE_S5;
            HDR_STEP9:  mode = MODE_S9;
            HDR_STEP17: mode = MODE_S17;
            HDR_COPY: begin
                mode = MODE_COPY;
                phase = PH_COPY;
            end
            default: begin
                push_word(0, ST_BADHDR);
                phase = PH_IDLE;
            end
        endcase
    endfunction

    function automatic void predict_word(logic op, logic [7:0] b, logic first, logic last);
        word_n = 0;
        if (op == OP_DRAIN) begin
            if (phase == PH_COPY)
                place_pixel(col_cnt < MAX_WIDTH ?
                            line_mem[(row_cnt & 1) * MAX_WIDTH + col_cnt] : 0, 0);
        end else begin
            if (first) clear_frame();
            case (phase)
                PH_HDR_HI: begin
                    hdr_hi = b;
                    phase = PH_HDR_LO;
                end
                PH_HDR_LO: take_header(b);
                PH_BODY: begin
                    if (mode == MODE_RAW || col_cnt < 2) begin
                        if (mode != MODE_RAW) bits_used = (bits_used + 8) & 16'h3FFF;
                        place_pixel(b, 1);
                    end else begin
                        if (bit_cnt > 10) begin
                            bit_cnt = 10;
                            bit_buf &= 'h3FF;
                        end
                        bit_buf = (bit_buf << 8) | b;
                        bit_cnt += 8;
                        decode_codes();
                    end
                end
                PH_PAD:  phase = PH_HDR_HI;
                PH_COPY: push_word(0, ST_INCOPY);
                default: ;
            endcase
            if (last && phase != PH_IDLE &&
                !(phase == PH_COPY && row_cnt + 1 >= height_now())) begin
                push_word(0, ST_SHORT);
                phase = PH_IDLE;
            end
        end
        if (word_n > 0) word_buf[word_n - 1].run_end = 1'b1;
        for (int i = 0; i < word_n; i++) owed_q.push_back(word_buf[i]);
    endfunction

    always @(posedge aclk) begin
        pixel_word_t exp_w, got_w;
        if (!aresetn) begin
            clear_frame();
            cfg_width  = WIDTH_RST;
            cfg_height = HEIGHT_RST;
            owed_q.delete();
            fail_count <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_WIDTH) cfg_width = pwdata[10:0];
                else cfg_height = pwdata[10:0];
            end
            if (s_tvalid && s_tready)
                predict_word(s_tuser[0], s_tdata, s_tuser[1], s_tlast);
            if (m_tvalid && m_tready) begin
                got_w = '{m_tdata[7:0], m_tdata[17:8], m_tdata[27:18], m_tlast,
                          m_tuser[0], m_tuser[2:1]};
                if (owed_q.size() == 0) begin
                    $display("%0t: unexpected word, got %h", $time, got_w);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_w = owed_q.pop_front();
                    if (exp_w != got_w) begin
                        $display("%0t: mismatch, expected pix %0d row %0d col %0d last %b done %b st %0d, got pix %0d row %0d col %0d last %b done %b st %0d",
                                 $time, exp_w.pix, exp_w.row, exp_w.col, exp_w.run_end,
                                 exp_w.done, exp_w.st, got_w.pix, got_w.row, got_w.col,
                                 got_w.run_end, got_w.done, got_w.st);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
        pixels_owed <= owed_q.size();
    end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import cbrd_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0, s_tready;
    logic [7:0]  s_tdata = 8'd0;   // [7:0] data_byte
    logic        s_tlast = 1'b0;   // frame_last
    logic [1:0]  s_tuser = 2'd0;   // [0] opcode, [1] frame_first
    logic        m_tvalid, m_tready = 1'b0;
    logic [31:0] m_tdata;          // [7:0] pixel, [17:8] pixel_row, [27:18] pixel_column
    logic        m_tlast;          // last_of_run
    logic [2:0]  m_tuser;          // [0] frame_done, [2:1] status
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0, prdata;
    logic        pready;
    int          fail_count, pixels_owed;

    // a byte or drain tick waiting to go into the block
    typedef struct {
        logic       op;
        logic [7:0] b;
        logic       first;
        logic       last;
    } stream_word_t;

    stream_word_t frame_q[$];
    int           code_plan[$];    // forced code choices for the next compressed row
    int           words_sent;
    int           cur_w, cur_h;
    bit           calm;            // stretch with no idling on the input side

    compressed_bayer_row_decoder u_top (.*);
    bayer_row_checker u_chk (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // abandon a run that hangs
    initial begin
        #40ms;
        $display("Test completed with failures");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // result side: ready for a while, then sometimes stall for a while
    initial begin
        @(posedge aclk iff aresetn);
        forever begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge aclk);
            if ($urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat (gap_len() + 1) @(posedge aclk);
            end
        end
    end

    task automatic put_word(stream_word_t w);
        int g;
        g = calm ? 0 : gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w.b;
        s_tlast  <= w.last;
        s_tuser  <= {w.first, w.op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        words_sent++;
    endtask

    // hold the input, wait until every owed word is out, then the block's latency
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pixels_owed != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic apb_write(logic idx, logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic set_geometry(int w, int h);
        settle();
        apb_write(REG_WIDTH, w);
        apb_write(REG_HEIGHT, h);
        cur_w = w < 2 ? 2 : (w > MAX_WIDTH ? MAX_WIDTH : w);
        cur_h = h < 1 ? 1 : (h > MAX_HEIGHT ? MAX_HEIGHT : h);
    endtask

    function automatic void add_byte(logic op, logic [7:0] b);
        frame_q.push_back('{op, b, 1'b0, 1'b0});
    endfunction

    function automatic void add_header(logic [15:0] hdr);
        add_byte(OP_DATA, hdr[15:8]);
        add_byte(OP_DATA, hdr[7:0]);
    endfunction

    function automatic void add_raw_row();
        add_header(HDR_RAW);
        for (int i = 0; i < cur_w; i++) add_byte(OP_DATA, $urandom_range(0, 255));
    endfunction

    // intrude: drop a stray data byte among the drain ticks
    function automatic void add_copy_row(bit intrude);
        int at;
        add_header(HDR_COPY);
        at = $urandom_range(0, cur_w - 1);
        for (int i = 0; i < cur_w; i++) begin
            if (intrude && i == at) add_byte(OP_DATA, $urandom_range(0, 255));
            add_byte(OP_DRAIN, $urandom_range(0, 255));
        end
    endfunction

    // codes 0..8 are the deltas in code-table order, 9 escape of zeros,
    // 10 escape of ones, 11 escape of random bits
    function automatic void add_comp_row(logic [15:0] hdr, int p0, int p1, bit last_row);
        bit    bits[$];
        int    esc, c, ev, nbytes;
        logic [7:0] acc;
        int    code_val[9] = '{0, 1, 2, 'hC, 'hD, 'h1C, 'h1D, 'h3C, 'h3D};
        int    code_len[9] = '{2, 2, 2, 4, 4, 5, 5, 6, 6};
        esc = hdr == HDR_STEP5 ? 6 : (hdr == HDR_STEP9 ? 5 : 4);
        add_header(hdr);
        add_byte(OP_DATA, p0);
        add_byte(OP_DATA, p1);
        for (int i = 2; i < cur_w; i++) begin
            if (code_plan.size() > 0) c = code_plan.pop_front();
            else c = $urandom_range(0, 3) == 0 ? 11 : $urandom_range(0, 8);
            if (c < 9) begin
                for (int k = code_len[c] - 1; k >= 0; k--) bits.push_back(code_val[c][k]);
            end else begin
                ev = c == 9 ? 0 : (c == 10 ? (1 << esc) - 1 : $urandom_range(0, (1 << esc) - 1));
                repeat (5) bits.push_back(1'b1);
                for (int k = esc - 1; k >= 0; k--) bits.push_back(ev[k]);
            end
        end
        nbytes = (bits.size() + 7) / 8;
        while (bits.size() < nbytes * 8) bits.push_back(1'b0);
        for (int i = 0; i < nbytes; i++) begin
            for (int k = 0; k < 8; k++) acc[7 - k] = bits[i * 8 + k];
            add_byte(OP_DATA, acc);
        end
        // pad the row to an even byte count; the last row's padding is never awaited
        if (!last_row && nbytes % 2 == 1) add_byte(OP_DATA, $urandom_range(0, 255));
    endfunction

    // mark the frame edges, optionally cut it short, and push it through
    task automatic send_frame(bit cut);
        int n;
        if (cut && frame_q.size() > 1) begin
            n = $urandom_range(1, frame_q.size() - 1);
            while (frame_q.size() > n) void'(frame_q.pop_back());
        end
        frame_q[0].first = 1'b1;
        for (int i = frame_q.size() - 1; i >= 0; i--) begin
            if (frame_q[i].op == OP_DATA) begin
                frame_q[i].last = 1'b1;
                break;
            end
        end
        foreach (frame_q[i]) put_word(frame_q[i]);
        frame_q.delete();
    endtask

    task automatic random_frame();
        int rows, r;
        logic [15:0] comp_hdr[3] = '{HDR_STEP5, HDR_STEP9, HDR_STEP17};
        rows = cur_h > 6 ? 4 : cur_h;
        for (int i = 0; i < rows; i++) begin
            r = $urandom_range(0, 99);
            if (r < 3) add_header($urandom_range(0, 16'hFFFF));
            else if (r < 23) add_raw_row();
            else if (r < 45) add_copy_row($urandom_range(0, 19) == 0);
            else add_comp_row(comp_hdr[$urandom_range(0, 2)], $urandom_range(0, 255),
                              $urandom_range(0, 255), i == rows - 1);
        end
        send_frame(rows < cur_h || $urandom_range(0, 9) == 0);
        // noise: stray bytes, drain ticks and frame marks
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 4))
                put_word('{$urandom_range(0, 1), $urandom_range(0, 255),
                           $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0});
        end
    endtask

    initial begin
        words_sent = 0;
        calm = 0;
        cur_w = WIDTH_RST;
        cur_h = HEIGHT_RST;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset geometry: one raw row cut short by an early frame end
        add_header(HDR_RAW);
        repeat (3) add_byte(OP_DATA, $urandom_range(0, 255));
        send_frame(0);
        // drain tick with no copy pending
        put_word('{OP_DRAIN, 8'hFF, 1'b1, 1'b1});

        // copy of the cleared store, all deltas, clipping at both ends,
        // escapes at both extremes, copy of a coded row with a stray byte
        set_geometry(12, 5);
        add_copy_row(0);
        code_plan = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9};
        add_comp_row(HDR_STEP5, 0, 255, 0);
        code_plan = '{7, 8, 7, 8, 6, 5, 10, 9, 0, 0};
        add_comp_row(HDR_STEP17, 3, 250, 0);
        code_plan = '{9, 10, 11, 9, 10, 1, 2, 3, 4, 0};
        add_comp_row(HDR_STEP9, 128, 127, 0);
        add_copy_row(1);
        send_frame(0);
        // unknown header, then bytes that must be ignored
        add_header(16'hFFFF);
        add_byte(OP_DATA, 8'h00);
        send_frame(0);

        // clamped extremes: narrowest single row, a wide row cut short, tallest frame
        set_geometry(0, 0);
        add_raw_row();
        send_frame(0);
        set_geometry(2047, 1);
        add_header(HDR_RAW);
        repeat (40) add_byte(OP_DATA, $urandom_range(0, 255));
        send_frame(0);
        set_geometry(3, 2047);
        add_raw_row();
        add_copy_row(0);
        send_frame(0);

        while (words_sent < 400) begin
            if ($urandom_range(0, 2) == 0)
                set_geometry($urandom_range(0, 9) == 0 ? $urandom_range(9, 24) :
                             $urandom_range(2, 8), $urandom_range(1, 4));
            calm = $urandom_range(0, 4) == 0;
            random_frame();
        end
        calm = 0;

        settle();
        if (fail_count == 0 && pixels_owed == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
